// ----- hw/rtl/rse_pkg.sv -----
// Package for the GF(256) Reed-Solomon encoder.
// Holds the field multiply, the generator polynomial tables and the cell control struct.
// No dependencies.
package rse_pkg;

  localparam int unsigned PRIM_POLY = 285;
  localparam int unsigned STRONG_T  = 16;
  localparam int unsigned WEAK_T    = 3;
  localparam int unsigned NUM_CELLS = 2 * STRONG_T;
  localparam int unsigned IDX_W     = $clog2(NUM_CELLS);

  localparam logic [IDX_W-1:0] STRONG_TOP = IDX_W'(2 * STRONG_T - 1);
  localparam logic [IDX_W-1:0] WEAK_TOP   = IDX_W'(2 * WEAK_T - 1);

  typedef logic [7:0] gen_t [0:NUM_CELLS];

  typedef struct packed {
    logic upd;    // advance parity register
    logic clr;    // clear parity register (codeword done)
    logic load;   // copy updated parity into output row
    logic shift;  // output row moves one cell up
  } cell_ctrl_t;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x ^= 9'(PRIM_POLY);
    end
    return acc;
  endfunction

  function automatic gen_t generator_coefs(int unsigned nroots);
    gen_t g;
    logic [7:0] root;
    for (int j = 0; j <= NUM_CELLS; j++) g[j] = '0;
    g[0] = 8'd1;
    root = 8'd1;
    for (int unsigned i = 1; i <= nroots; i++) begin
      root = gf_mul(root, 8'd2);
      for (int unsigned j = i; j > 0; j--) g[j] = g[j-1] ^ gf_mul(g[j], root);
      g[0] = gf_mul(g[0], root);
    end
    return g;
  endfunction

  localparam gen_t GEN_STRONG = generator_coefs(2 * STRONG_T);
  localparam gen_t GEN_WEAK   = generator_coefs(2 * WEAK_T);

endpackage

// ----- hw/rtl/rse_cell.sv -----
// One cell of the encoder chain: a parity register and an output-row register.
// Depends on rse_pkg (gf_mul, cell_ctrl_t).
module rse_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rse_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          coef_i,
  input  logic [7:0]          fb_i,
  input  logic [7:0]          par_prev_i,
  input  logic [7:0]          out_prev_i,
  output logic [7:0]          par_o,
  output logic [7:0]          out_o
);
  import rse_pkg::*;

  logic [7:0] par_q, par_d, par_new;
  logic [7:0] out_q, out_d;

  assign par_new = ctrl_i.upd ? (par_prev_i ^ gf_mul(coef_i, fb_i)) : par_q;
  assign par_d   = ctrl_i.clr ? 8'd0 : par_new;

  always_comb begin
    out_d = out_q;
    if (ctrl_i.load) begin
      out_d = par_new;
    end else if (ctrl_i.shift) begin
      out_d = out_prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= '0;
    end else begin
      par_q <= par_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign par_o = par_q;
  assign out_o = out_q;
endmodule

// ----- hw/rtl/reed_solomon_encoder_gf256.sv -----
// Systematic RS encoder over GF(256): chain of 32 LFSR cells plus an output row.
// Latency: first parity symbol valid the cycle after the last message symbol.
// Throughput: one message symbol per cycle, save the stall below; 2T parity symbols drain one per ready cycle.
// A symbol marked last stalls while the previous parity run still drains the output row.
// Reset: parity registers cleared, strong mode (T=16) selected, no parity pending.
// Depends on rse_pkg and rse_cell.
module reed_solomon_encoder_gf256 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     strong_mode_we_i,
  input  logic                     strong_mode_i,
  input  logic                     data_valid_i,
  output logic                     data_ready_o,
  input  logic [7:0]               data_symbol_i,
  input  logic                     last_data_i,
  output logic                     parity_valid_o,
  input  logic                     parity_ready_i,
  output logic [7:0]               parity_symbol_o,
  output logic [rse_pkg::IDX_W-1:0] parity_index_o,
  output logic                     last_parity_o
);
  import rse_pkg::*;

  logic                 strong_q;
  logic                 busy_q, busy_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 omode_q, omode_d;
  logic                 in_acc, out_acc, load;
  logic [7:0]           fb;
  logic [7:0]           par  [NUM_CELLS];
  logic [7:0]           orow [NUM_CELLS];

  assign data_ready_o = !(busy_q && last_data_i);
  assign in_acc       = data_valid_i && data_ready_o;
  assign out_acc      = parity_valid_o && parity_ready_i;
  assign load         = in_acc && last_data_i;

  assign fb = data_symbol_i ^ (strong_q ? par[STRONG_TOP] : par[WEAK_TOP]);

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] coef, par_prev, out_prev;

    assign ctrl.upd   = in_acc && (strong_q || (j < 2 * WEAK_T));
    assign ctrl.clr   = load;
    assign ctrl.load  = load;
    assign ctrl.shift = out_acc;
    assign coef       = strong_q ? GEN_STRONG[j] : GEN_WEAK[j];

    if (j == 0) begin : g_first
      assign par_prev = 8'd0;
      assign out_prev = 8'd0;
    end else begin : g_rest
      assign par_prev = par[j-1];
      assign out_prev = orow[j-1];
    end

    rse_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .coef_i     (coef),
      .fb_i       (fb),
      .par_prev_i (par_prev),
      .out_prev_i (out_prev),
      .par_o      (par[j]),
      .out_o      (orow[j])
    );
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    omode_d = omode_q;
    if (load) begin
      busy_d  = 1'b1;
      idx_d   = strong_q ? STRONG_TOP : WEAK_TOP;
      omode_d = strong_q;
    end else if (out_acc) begin
      if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strong_q <= 1'b1;
      busy_q   <= 1'b0;
      idx_q    <= '0;
      omode_q  <= 1'b1;
    end else begin
      if (strong_mode_we_i) begin
        strong_q <= strong_mode_i;
      end
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      omode_q <= omode_d;
    end
  end

  assign parity_valid_o  = busy_q;
  assign parity_symbol_o = omode_q ? orow[STRONG_TOP] : orow[WEAK_TOP];
  assign parity_index_o  = idx_q;
  assign last_parity_o   = (idx_q == '0);
endmodule

// ----- hw/rtl/rse_checker.sv -----
// Port-level checks for reed_solomon_encoder_gf256, bound to the top level.
// Depends on rse_pkg for the index width and the top indices.
module rse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      data_valid_i,
  input logic                      data_ready_o,
  input logic                      last_data_i,
  input logic                      parity_valid_o,
  input logic                      parity_ready_i,
  input logic [7:0]                parity_symbol_o,
  input logic [rse_pkg::IDX_W-1:0] parity_index_o,
  input logic                      last_parity_o
);
  import rse_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parity_valid_o && !parity_ready_i |=>
      parity_valid_o && $stable(parity_symbol_o) && $stable(parity_index_o))
    else $error("parity transaction changed while stalled");

  a_idx_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parity_valid_o && parity_ready_i && !last_parity_o |=>
      parity_valid_o && (parity_index_o == $past(parity_index_o) - 1'b1))
    else $error("parity index did not step down");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parity_valid_o |-> (last_parity_o == (parity_index_o == '0)))
    else $error("last_parity does not match index zero");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_valid_i && data_ready_o && last_data_i |=>
      parity_valid_o && (parity_index_o == STRONG_TOP || parity_index_o == WEAK_TOP))
    else $error("parity run did not start at top index");
endmodule

bind reed_solomon_encoder_gf256 rse_checker u_rse_checker (.*);
